[sv/eeb_pkg.sv]
// Shared constants and types for the extended Euclid / Bezout block.
package eeb_pkg;

   localparam int OPERAND_WIDTH = 32;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_STEP  = 5'b00010,
      ST_ALIGN = 5'b00100,
      ST_SUB   = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

endpackage

[sv/extended_euclid_bezout.sv]
// Extended Euclid: gcd with Bezout coefficients, one shared shift/subtract unit.
//
//  channel | dir | fields (low bit up)                    | handshake
//  req     | in  | operand_a, operand_b                   | req_tvalid / req_tready
//  rsp     | out | divisor, coef_a, coef_b                | rsp_tvalid / rsp_tready
//
// Each division step of Euclid runs a set-up state, divisor alignment, then
// restoring subtraction one quotient bit a cycle on the shared shift/subtract
// unit; a final set-up state sees the zero remainder and the result is then
// offered on the rsp channel.
// Reset is synchronous and clears only the sequencer.
// req_tready is high only while idle; a result word holds until rsp_tready.
module extended_euclid_bezout #(
   parameter int OPERAND_WIDTH = eeb_pkg::OPERAND_WIDTH,
   localparam int W     = OPERAND_WIDTH,
   localparam int REQ_W = ((2 * W + 7) / 8) * 8,
   localparam int RSP_W = ((3 * W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // operand_a, operand_b
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // divisor, coef_a, coef_b
);

   localparam int CW = $clog2(W);

   eeb_pkg::state_type state_ff, state_in;

   logic [W-1:0]  r0_ff, r1_ff, s0_ff, s1_ff, t0_ff, t1_ff;
   logic [W-1:0]  rem_ff, ns_ff, nt_ff, d_ff;
   logic [CW-1:0] cnt_ff;

   logic          d_le;
   logic          can_grow;
   logic [W-1:0]  rem_nx, ns_nx, nt_nx;

   assign d_le     = (d_ff <= rem_ff);
   assign can_grow = !d_ff[W-1] && ((d_ff << 1) <= rem_ff);

   always_comb begin
      rem_nx = rem_ff;
      ns_nx  = ns_ff;
      nt_nx  = nt_ff;
      if (d_le) begin
         rem_nx = rem_ff - d_ff;
         ns_nx  = ns_ff - (s1_ff << cnt_ff);
         nt_nx  = nt_ff - (t1_ff << cnt_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         eeb_pkg::ST_IDLE:  if (req_tvalid) state_in = eeb_pkg::ST_STEP;
         eeb_pkg::ST_STEP: begin
            if (r1_ff == '0) state_in = eeb_pkg::ST_DONE;
            else             state_in = eeb_pkg::ST_ALIGN;
         end
         eeb_pkg::ST_ALIGN: if (!can_grow) state_in = eeb_pkg::ST_SUB;
         eeb_pkg::ST_SUB:   if (cnt_ff == '0) state_in = eeb_pkg::ST_STEP;
         eeb_pkg::ST_DONE:  if (rsp_tready) state_in = eeb_pkg::ST_IDLE;
         default:           state_in = eeb_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= eeb_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         eeb_pkg::ST_IDLE: begin
            r0_ff <= req_tdata[W-1:0];
            r1_ff <= req_tdata[2*W-1:W];
            s0_ff <= W'(1);
            s1_ff <= '0;
            t0_ff <= '0;
            t1_ff <= W'(1);
         end
         eeb_pkg::ST_STEP: begin
            rem_ff <= r0_ff;
            ns_ff  <= s0_ff;
            nt_ff  <= t0_ff;
            d_ff   <= r1_ff;
            cnt_ff <= '0;
         end
         eeb_pkg::ST_ALIGN: begin
            if (can_grow) begin
               d_ff   <= d_ff << 1;
               cnt_ff <= cnt_ff + CW'(1);
            end
         end
         eeb_pkg::ST_SUB: begin
            rem_ff <= rem_nx;
            ns_ff  <= ns_nx;
            nt_ff  <= nt_nx;
            d_ff   <= d_ff >> 1;
            cnt_ff <= cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               r0_ff <= r1_ff;
               r1_ff <= rem_nx;
               s0_ff <= s1_ff;
               s1_ff <= ns_nx;
               t0_ff <= t1_ff;
               t1_ff <= nt_nx;
            end
         end
         default: begin
         end
      endcase
   end

   assign req_tready = (state_ff == eeb_pkg::ST_IDLE);
   assign rsp_tvalid = (state_ff == eeb_pkg::ST_DONE);
   assign rsp_tdata  = RSP_W'({t0_ff, s0_ff, r0_ff});

endmodule

[sv/eeb_checker.sv]
// Port-level checks for the extended Euclid block, bound to the top level.
module eeb_checker #(
   parameter int OPERAND_WIDTH = eeb_pkg::OPERAND_WIDTH,
   localparam int W     = OPERAND_WIDTH,
   localparam int REQ_W = ((2 * W + 7) / 8) * 8,
   localparam int RSP_W = ((3 * W + 7) / 8) * 8
) (
   input logic             clock,
   input logic             reset,
   input logic             req_tvalid,
   input logic             req_tready,
   input logic [REQ_W-1:0] req_tdata,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("ready for a new word while a result is pending");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("block not busy after accepting a word");

   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |=> req_tready)
      else $error("block not idle after result taken");

   a_zero_gcd: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[W-1:0] == '0 |->
         rsp_tdata[2*W-1:W] == W'(1) && rsp_tdata[3*W-1:2*W] == '0)
      else $error("zero divisor without coefficients 1, 0");

   logic unused_req;
   assign unused_req = ^req_tdata;

endmodule

bind extended_euclid_bezout eeb_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_eeb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[dv/bezout_checker.sv]
`timescale 1ns / 1ps
// Checker for the Bezout block: watches both streams, predicts each result word and compares.
module bezout_checker #(
   parameter int W     = eeb_pkg::OPERAND_WIDTH,
   parameter int REQ_W = ((2 * W + 7) / 8) * 8,
   parameter int RSP_W = ((3 * W + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // operand_a, operand_b
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,   // divisor, coef_a, coef_b
   output int               mismatches,
   output int               outstanding
);

   typedef struct {
      logic [W-1:0]        divisor;
      logic signed [W-1:0] coef_a;
      logic signed [W-1:0] coef_b;
   } bezout_word_type;

   bezout_word_type expected_words[$];
   int              errors = 0;

   // remainder sequence with coefficients carried modulo 2^64
   function automatic bezout_word_type bezout_of(logic [W-1:0] a, logic [W-1:0] b);
      logic [63:0]     r0, r1, s0, s1, t0, t1, q, nr, ns, nt;
      bezout_word_type res;
      r0 = 64'(a);
      r1 = 64'(b);
      s0 = 64'd1;
      s1 = 64'd0;
      t0 = 64'd0;
      t1 = 64'd1;
      while (r1 != 64'd0) begin
         q  = r0 / r1;
         nr = r0 - q * r1;
         ns = s0 - q * s1;
         nt = t0 - q * t1;
         r0 = r1;
         r1 = nr;
         s0 = s1;
         s1 = ns;
         t0 = t1;
         t1 = nt;
      end
      res.divisor = r0[W-1:0];
      res.coef_a  = s0[W-1:0];
      res.coef_b  = t0[W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      bezout_word_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.divisor = rsp_tdata[W-1:0];
            got.coef_a  = rsp_tdata[2*W-1:W];
            got.coef_b  = rsp_tdata[3*W-1:2*W];
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected: divisor %0d", got.divisor);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (got.divisor !== want.divisor) begin
                  $error("divisor: expected %0d, got %0d", want.divisor, got.divisor);
                  errors++;
               end
               if (got.coef_a !== want.coef_a) begin
                  $error("coef_a: expected %0d, got %0d", want.coef_a, got.coef_a);
                  errors++;
               end
               if (got.coef_b !== want.coef_b) begin
                  $error("coef_b: expected %0d, got %0d", want.coef_b, got.coef_b);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_words = {expected_words,
                              bezout_of(req_tdata[W-1:0], req_tdata[2*W-1:W])};
      end
      mismatches  <= errors;
      outstanding <= expected_words.size();
   end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Top of the Bezout block testbench: clock, reset, operand stimulus, result back-pressure, verdict.
module tb_top;

   localparam int W            = eeb_pkg::OPERAND_WIDTH;
   localparam int REQ_W        = ((2 * W + 7) / 8) * 8;
   localparam int RSP_W        = ((3 * W + 7) / 8) * 8;
   localparam int RANDOM_WORDS = 930;
   localparam int TAIL_CYCLES  = 300;
   localparam int LIMIT        = 1000000;
   localparam int HOLD_START   = 8000;
   localparam int HOLD_CYCLES  = 600;
   localparam logic [W-1:0] ALL_ONES = '1;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;    // operand_a, operand_b
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;    // divisor, coef_a, coef_b
   int               mismatches;
   int               outstanding;

   extended_euclid_bezout dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bezout_checker #(.W(W), .REQ_W(REQ_W), .RSP_W(RSP_W)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL");
      $finish;
   end

   task automatic send_word(input logic [W-1:0] a, input logic [W-1:0] b);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({b, a});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic logic [W-1:0] corner_value();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return W'(1);
         2:       return W'(2);
         3:       return ALL_ONES;
         4:       return ALL_ONES - W'(1);
         default: return W'(1) << (W - 1);
      endcase
   endfunction

   task automatic pick_operands(output logic [W-1:0] a, output logic [W-1:0] b);
      logic [W-1:0] g, f0, f1, f2;
      int           k;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            a = W'($urandom);
            b = W'($urandom);
         end
         4: begin
            a = W'($urandom) >> $urandom_range(0, W - 1);
            b = W'($urandom) >> $urandom_range(0, W - 1);
         end
         5: begin
            g = W'($urandom_range(1, 65535));
            a = g * W'($urandom_range(0, 65535));
            b = g * W'($urandom_range(1, 65535));
         end
         6: begin
            if ($urandom_range(0, 1)) begin
               a = W'($urandom);
               b = '0;
            end else begin
               a = '0;
               b = W'($urandom);
            end
         end
         7: begin
            // consecutive Fibonacci numbers: longest remainder chains
            f0 = '0;
            f1 = W'(1);
            k  = $urandom_range(1, 46);
            repeat (k) begin
               f2 = f0 + f1;
               f0 = f1;
               f1 = f2;
            end
            if ($urandom_range(0, 1)) begin
               a = f1;
               b = f0;
            end else begin
               a = f0;
               b = f1;
            end
         end
         8: begin
            a = W'($urandom);
            b = a - W'($urandom_range(0, 3));
         end
         default: begin
            a = corner_value();
            b = corner_value();
         end
      endcase
   endtask

   // result side: random stall patterns, one long hold-off while the sender keeps offering
   initial begin
      int cycles, len, mode;
      bit held;
      rsp_tready = 1'b0;
      cycles = 0;
      held = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held && cycles > HOLD_START) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            cycles += HOLD_CYCLES;
            held = 1'b1;
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(1, 64);
         repeat (len) begin
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= $urandom_range(0, 1);
               2:       rsp_tready <= ($urandom_range(0, 7) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
            @(posedge clock);
            cycles++;
         end
      end
   end

   initial begin
      int           sent, burst, gap;
      logic [W-1:0] a, b;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero operands, extremes, long chains, large quotients
      send_word('0, '0);
      send_word(W'(12345), '0);
      send_word('0, W'(6789));
      send_word('0, ALL_ONES);
      send_word(ALL_ONES, '0);
      send_word(W'(1), W'(1));
      send_word(ALL_ONES, ALL_ONES);
      send_word(ALL_ONES, W'(1));
      send_word(W'(1), ALL_ONES);
      send_word(ALL_ONES, ALL_ONES - W'(1));
      send_word(W'(32'd2971215073), W'(32'd1836311903));
      send_word(W'(32'd1836311903), W'(32'd2971215073));
      send_word(W'(32'h8000_0000), W'(1));
      send_word(W'(32'h8000_0000), W'(32'h8000_0000));
      send_word(W'(32'hFFFF_0000), W'(32'h0FFF_F000));
      send_word(W'(32'd4294967291), W'(32'd4294967279));
      send_word(W'(240), W'(46));
      send_word(W'(17), W'(3120));
      send_word(W'(7), W'(7));
      send_word(W'(32'h5555_5555), W'(32'hAAAA_AAAA));
      send_word(W'(32'hAAAA_AAAA), W'(32'h5555_5555));
      wait_drained();

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && sent < RANDOM_WORDS) begin
            pick_operands(a, b);
            send_word(a, b);
            sent++;
            burst--;
            if (sent == RANDOM_WORDS / 2)
               wait_drained();
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[extended_euclid_bezout.f]
sv/eeb_pkg.sv
sv/extended_euclid_bezout.sv
sv/eeb_checker.sv
dv/bezout_checker.sv
dv/tb_top.sv
